FILE: src/sed135_pkg.sv
// Shared types, constants and sign/class helpers for the SAO 135-degree statistics block.
`timescale 1ns / 1ps

package sed135_pkg;

    localparam int NUM_CLASSES = 5;
    localparam int CLASS_W     = 3;
    localparam int SUM_W       = 32;
    localparam int CNT_W       = 31;
    localparam int DIFF_W      = 16;
    localparam int PIX_W       = 8;
    localparam int TOT_W       = 3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    localparam logic [1:0] SIGN_CODE_ZERO = 2'b00;
    localparam logic [1:0] SIGN_CODE_POS  = 2'b01;

    typedef logic signed [1:0]   sign_t;
    typedef logic [CLASS_W-1:0]  class_idx_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef struct packed {
        sign_t      next_sign;
        sign_t      start_sign;
        class_idx_t cls;
    } class_info_t;

    // Sign of (a - b) for unsigned pixels.
    function automatic sign_t pixel_sign(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        sign_t s;
        if (a > b)
            s = 2'sd1;
        else if (a < b)
            s = -2'sd1;
        else
            s = 2'sd0;
        return s;
    endfunction

    // Decode a stored 2-bit sign; the unused code -2 saturates to -1.
    function automatic sign_t decode_sign(input logic [1:0] code);
        sign_t s;
        case (code)
            SIGN_CODE_ZERO: s = 2'sd0;
            SIGN_CODE_POS:  s = 2'sd1;
            default:        s = -2'sd1;
        endcase
        return s;
    endfunction

    // Edge type -2,-1,0,1,2 maps to class 1,2,0,3,4.
    function automatic class_idx_t edge_class(input logic signed [2:0] edge_type);
        class_idx_t c;
        case (edge_type)
            -3'sd2:  c = 3'd1;
            -3'sd1:  c = 3'd2;
            3'sd0:   c = 3'd0;
            3'sd1:   c = 3'd3;
            default: c = 3'd4;
        endcase
        return c;
    endfunction

endpackage

FILE: src/sed135_class.sv
// Edge classification: down sign, edge class and the signs stored for the next row.
`timescale 1ns / 1ps

module sed135_class (
    input  logic [sed135_pkg::PIX_W-1:0] cur_pixel,
    input  logic [sed135_pkg::PIX_W-1:0] diag_pixel,
    input  logic [1:0]                   up_sign,
    input  logic                         row_start,
    input  logic [sed135_pkg::PIX_W-1:0] left_pixel,
    input  logic [sed135_pkg::PIX_W-1:0] below_pixel,
    output sed135_pkg::class_info_t      info
);
    import sed135_pkg::*;

    sign_t              down_sign;
    sign_t              up_dec;
    logic signed [2:0]  edge_type;

    always_comb
    begin
        down_sign = pixel_sign(cur_pixel, diag_pixel);
        up_dec    = decode_sign(up_sign);
        edge_type = 3'(down_sign) + 3'(up_dec);

        info.cls        = edge_class(edge_type);
        info.next_sign  = -down_sign;
        info.start_sign = row_start ? pixel_sign(below_pixel, left_pixel) : 2'sd0;
    end

endmodule

FILE: src/sao_edge_diag135_stats_top.sv
// Top level of the SAO edge-offset 135-degree statistics block.
`timescale 1ns / 1ps

// Usage:
//   Pixel channel (pix_valid / pix_stall): one transaction per pixel with the current
//   and lower-right pixels, the stored up sign, the diff, and row_start / end_of_block /
//   clear_before flags. Result channel (res_valid / res_stall): one pixel result per
//   pixel; an end_of_block pixel is followed by five class totals, class 0 to 4, and
//   last marks the final result of each pixel transaction.
// Pipeline: an accepted pixel is held in the input register; its result is then
//   registered in the result register and shows on the result ports from then on.
// Throughput: one pixel per cycle while the receiver takes results. An end_of_block
//   pixel occupies the result register for its pixel result plus five totals,
//   during which the next pixel waits in the input register.
// Reset: clears all class sums and counts and drops any transaction in flight.
// Receiver stall: hold the result register; the input register still takes one
//   pixel, then pix_stall rises until the result register frees up.
module sao_edge_diag135_stats_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  logic [sed135_pkg::PIX_W-1:0]      cur_pixel,
    input  logic [sed135_pkg::PIX_W-1:0]      diag_pixel,
    input  logic signed [1:0]                 up_sign,
    input  logic signed [sed135_pkg::DIFF_W-1:0] diff,
    input  logic                              row_start,
    input  logic [sed135_pkg::PIX_W-1:0]      left_pixel,
    input  logic [sed135_pkg::PIX_W-1:0]      below_pixel,
    input  logic                              end_of_block,
    input  logic                              clear_before,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              kind,
    output logic signed [1:0]                 next_up_sign,
    output logic signed [1:0]                 start_up_sign,
    output logic [sed135_pkg::CLASS_W-1:0]    class_index,
    output logic signed [sed135_pkg::SUM_W-1:0] class_sum,
    output logic [sed135_pkg::CNT_W-1:0]      class_count,
    output logic                              last
);
    import sed135_pkg::*;

    // Input register
    logic                 in_valid_reg, in_valid_next;
    logic [PIX_W-1:0]     cur_reg, diag_reg, left_reg, below_reg;
    logic [1:0]           up_reg;
    logic [DIFF_W-1:0]    diff_reg;
    logic                 row_start_reg, eob_reg, clear_reg;

    // Class statistics, one lane per class
    sum_t                 sum_reg  [NUM_CLASSES];
    cnt_t                 cnt_reg  [NUM_CLASSES];
    sum_t                 sum_next [NUM_CLASSES];
    cnt_t                 cnt_next [NUM_CLASSES];

    // Snapshot line for the end-of-block totals, shifted out at lane 0
    sum_t                 tot_sum_reg  [NUM_CLASSES];
    cnt_t                 tot_cnt_reg  [NUM_CLASSES];
    sum_t                 tot_sum_next [NUM_CLASSES];
    cnt_t                 tot_cnt_next [NUM_CLASSES];
    logic [TOT_W-1:0]     tot_left_reg, tot_left_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg, kind_next;
    sign_t                nus_reg, nus_next;
    sign_t                sus_reg, sus_next;
    class_idx_t           cls_reg, cls_next;
    sum_t                 osum_reg, osum_next;
    cnt_t                 ocnt_reg, ocnt_next;
    logic                 last_reg, last_next;

    class_info_t          info;
    logic                 out_free;
    logic                 consume;
    logic                 pix_accept;
    sum_t                 diff_ext;
    sum_t                 pix_sum;
    cnt_t                 pix_cnt;

    sed135_class u_class (
        .cur_pixel   (cur_reg),
        .diag_pixel  (diag_reg),
        .up_sign     (up_reg),
        .row_start   (row_start_reg),
        .left_pixel  (left_reg),
        .below_pixel (below_reg),
        .info        (info)
    );

    // Result slot frees when empty or taken this cycle; totals go before the next pixel.
    assign out_free   = !out_valid_reg || !res_stall;
    assign consume    = in_valid_reg && out_free && (tot_left_reg == '0);
    assign pix_stall  = in_valid_reg && !consume;
    assign pix_accept = pix_valid && !pix_stall;
    assign diff_ext   = SUM_W'($signed(diff_reg));

    // Per-lane update: clear first, then count the pixel in its class.
    always_comb
    begin
        pix_sum = '0;
        pix_cnt = '0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            sum_next[k] = clear_reg ? '0 : sum_reg[k];
            cnt_next[k] = clear_reg ? '0 : cnt_reg[k];
            if (info.cls == CLASS_W'(k))
            begin
                sum_next[k] = sum_next[k] + diff_ext;
                if (cnt_next[k] != '1)
                    cnt_next[k] = cnt_next[k] + 1'b1;
            end
            // one-hot select of the updated lane for the pixel result
            if (info.cls == CLASS_W'(k))
            begin
                pix_sum = sum_next[k];
                pix_cnt = cnt_next[k];
            end
        end
    end

    // Result register and totals sequencing
    always_comb
    begin
        in_valid_next  = pix_accept ? 1'b1 : (consume ? 1'b0 : in_valid_reg);
        out_valid_next = out_valid_reg && res_stall;
        kind_next      = kind_reg;
        nus_next       = nus_reg;
        sus_next       = sus_reg;
        cls_next       = cls_reg;
        osum_next      = osum_reg;
        ocnt_next      = ocnt_reg;
        last_next      = last_reg;
        tot_left_next  = tot_left_reg;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            tot_sum_next[k] = tot_sum_reg[k];
            tot_cnt_next[k] = tot_cnt_reg[k];
        end

        if ((tot_left_reg != '0) && out_free)
        begin
            // emit the head of the snapshot line and advance it
            out_valid_next = 1'b1;
            kind_next      = KIND_TOTAL;
            nus_next       = 2'sd0;
            sus_next       = 2'sd0;
            cls_next       = CLASS_W'(NUM_CLASSES) - CLASS_W'(tot_left_reg);
            osum_next      = tot_sum_reg[0];
            ocnt_next      = tot_cnt_reg[0];
            last_next      = (tot_left_reg == TOT_W'(1));
            tot_left_next  = tot_left_reg - 1'b1;
            for (int k = 0; k < NUM_CLASSES - 1; k++)
            begin
                tot_sum_next[k] = tot_sum_reg[k+1];
                tot_cnt_next[k] = tot_cnt_reg[k+1];
            end
        end
        else if (consume)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_PIXEL;
            nus_next       = info.next_sign;
            sus_next       = info.start_sign;
            cls_next       = info.cls;
            osum_next      = pix_sum;
            ocnt_next      = pix_cnt;
            last_next      = !eob_reg;
            if (eob_reg)
            begin
                tot_left_next = TOT_W'(NUM_CLASSES);
                for (int k = 0; k < NUM_CLASSES; k++)
                begin
                    tot_sum_next[k] = sum_next[k];
                    tot_cnt_next[k] = cnt_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tot_left_reg  <= '0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                sum_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            tot_left_reg  <= tot_left_next;
            if (consume)
            begin
                for (int k = 0; k < NUM_CLASSES; k++)
                begin
                    sum_reg[k] <= sum_next[k];
                    cnt_reg[k] <= cnt_next[k];
                end
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            cur_reg       <= cur_pixel;
            diag_reg      <= diag_pixel;
            up_reg        <= up_sign;
            diff_reg      <= diff;
            row_start_reg <= row_start;
            left_reg      <= left_pixel;
            below_reg     <= below_pixel;
            eob_reg       <= end_of_block;
            clear_reg     <= clear_before;
        end
        kind_reg <= kind_next;
        nus_reg  <= nus_next;
        sus_reg  <= sus_next;
        cls_reg  <= cls_next;
        osum_reg <= osum_next;
        ocnt_reg <= ocnt_next;
        last_reg <= last_next;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            tot_sum_reg[k] <= tot_sum_next[k];
            tot_cnt_reg[k] <= tot_cnt_next[k];
        end
    end

    assign res_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign next_up_sign  = nus_reg;
    assign start_up_sign = sus_reg;
    assign class_index   = cls_reg;
    assign class_sum     = osum_reg;
    assign class_count   = ocnt_reg;
    assign last          = last_reg;

endmodule

FILE: tb/sv/sao_diag135_stats_checker.sv
// Checker that predicts and compares the 135-degree SAO edge statistics results.
`timescale 1ns / 1ps

module sao_diag135_stats_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pix_valid,
    input  logic                                 pix_stall,
    input  logic [sed135_pkg::PIX_W-1:0]         cur_pixel,
    input  logic [sed135_pkg::PIX_W-1:0]         diag_pixel,
    input  logic signed [1:0]                    up_sign,
    input  logic signed [sed135_pkg::DIFF_W-1:0] diff,
    input  logic                                 row_start,
    input  logic [sed135_pkg::PIX_W-1:0]         left_pixel,
    input  logic [sed135_pkg::PIX_W-1:0]         below_pixel,
    input  logic                                 end_of_block,
    input  logic                                 clear_before,
    input  logic                                 res_valid,
    input  logic                                 res_stall,
    input  logic                                 kind,
    input  logic signed [1:0]                    next_up_sign,
    input  logic signed [1:0]                    start_up_sign,
    input  logic [sed135_pkg::CLASS_W-1:0]       class_index,
    input  logic signed [sed135_pkg::SUM_W-1:0]  class_sum,
    input  logic [sed135_pkg::CNT_W-1:0]         class_count,
    input  logic                                 last,
    output int                                   fail_count,
    output int                                   pending
);
    import sed135_pkg::*;

    typedef struct packed {
        logic       kind;
        sign_t      next_sign;
        sign_t      start_sign;
        class_idx_t cls;
        sum_t       sum;
        cnt_t       cnt;
        logic       last;
    } stat_result_t;

    sum_t         sum_acc [NUM_CLASSES];
    cnt_t         cnt_acc [NUM_CLASSES];
    stat_result_t stats_due [$];

    function automatic int diff_sign(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        if (a > b)
            return 1;
        if (a < b)
            return -1;
        return 0;
    endfunction

    // Both negative codes read as -1; the unused -2 code saturates.
    function automatic int up_value(input logic [1:0] code);
        if (code == SIGN_CODE_ZERO)
            return 0;
        if (code == SIGN_CODE_POS)
            return 1;
        return -1;
    endfunction

    function automatic class_idx_t class_of_edge(input int edge_type);
        case (edge_type)
            -2:      return 3'd1;
            -1:      return 3'd2;
            0:       return 3'd0;
            1:       return 3'd3;
            default: return 3'd4;
        endcase
    endfunction

    // Update the class statistics for one pixel and queue what it should produce.
    task automatic account_pixel();
        int           s;
        int           k;
        class_idx_t   c;
        stat_result_t r;
        if (clear_before)
        begin
            for (k = 0; k < NUM_CLASSES; k++)
            begin
                sum_acc[k] = '0;
                cnt_acc[k] = '0;
            end
        end
        s = diff_sign(cur_pixel, diag_pixel);
        c = class_of_edge(s + up_value(up_sign));
        sum_acc[c] = sum_acc[c] + {{(SUM_W-DIFF_W){diff[DIFF_W-1]}}, diff};
        if (cnt_acc[c] != {CNT_W{1'b1}})
            cnt_acc[c] = cnt_acc[c] + 1'b1;
        r.kind       = KIND_PIXEL;
        r.next_sign  = sign_t'(-s);
        r.start_sign = row_start ? sign_t'(diff_sign(below_pixel, left_pixel)) : sign_t'(0);
        r.cls        = c;
        r.sum        = sum_acc[c];
        r.cnt        = cnt_acc[c];
        r.last       = !end_of_block;
        stats_due.push_back(r);
        if (end_of_block)
        begin
            for (k = 0; k < NUM_CLASSES; k++)
            begin
                r.kind       = KIND_TOTAL;
                r.next_sign  = sign_t'(0);
                r.start_sign = sign_t'(0);
                r.cls        = class_idx_t'(k);
                r.sum        = sum_acc[k];
                r.cnt        = cnt_acc[k];
                r.last       = (k == NUM_CLASSES - 1);
                stats_due.push_back(r);
            end
        end
    endtask

    task automatic check_result();
        stat_result_t got;
        stat_result_t want;
        got = {kind, next_up_sign, start_up_sign, class_index, class_sum, class_count, last};
        if (stats_due.size() == 0)
        begin
            if (fail_count < 10)
                $display("unexpected result: kind=%0d cls=%0d sum=%0d cnt=%0d last=%0d",
                         got.kind, got.cls, got.sum, got.cnt, got.last);
            fail_count = fail_count + 1;
        end
        else
        begin
            want = stats_due.pop_front();
            if (got.kind != want.kind || got.next_sign != want.next_sign ||
                got.start_sign != want.start_sign || got.cls != want.cls ||
                got.sum != want.sum || got.cnt != want.cnt || got.last != want.last)
            begin
                if (fail_count < 10)
                begin
                    $display("exp: kind=%0d nus=%0d sus=%0d cls=%0d sum=%0d cnt=%0d last=%0d",
                             want.kind, want.next_sign, want.start_sign, want.cls,
                             want.sum, want.cnt, want.last);
                    $display("act: kind=%0d nus=%0d sus=%0d cls=%0d sum=%0d cnt=%0d last=%0d",
                             got.kind, got.next_sign, got.start_sign, got.cls,
                             got.sum, got.cnt, got.last);
                end
                fail_count = fail_count + 1;
            end
        end
    endtask

    // Compare before queueing: a pixel taken at this edge cannot have a result yet.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                sum_acc[k] = '0;
                cnt_acc[k] = '0;
            end
            stats_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result();
            if (pix_valid && !pix_stall)
                account_pixel();
        end
        pending = stats_due.size();
    end

endmodule

FILE: tb/sv/tb_sao_edge_diag135_stats_top.sv
// Testbench top: pixel stimulus, result-side stalls and the final verdict.
`timescale 1ns / 1ps

module tb_sao_edge_diag135_stats_top;
    import sed135_pkg::*;

    // Negative sign codes; the package only names zero and plus one.
    localparam logic [1:0] SIGN_CODE_NEG = 2'b11;
    localparam logic [1:0] SIGN_CODE_BAD = 2'b10;

    localparam int RAND_ITEMS   = 330;
    localparam int DRAIN_CYCLES = 12;

    // Every input starts at a known value before reset is released.
    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     pix_valid     = 1'b0;
    logic [PIX_W-1:0]         cur_pixel     = '0;
    logic [PIX_W-1:0]         diag_pixel    = '0;
    logic signed [1:0]        up_sign       = '0;
    logic signed [DIFF_W-1:0] diff          = '0;
    logic                     row_start     = 1'b0;
    logic [PIX_W-1:0]         left_pixel    = '0;
    logic [PIX_W-1:0]         below_pixel   = '0;
    logic                     end_of_block  = 1'b0;
    logic                     clear_before  = 1'b0;
    logic                     res_stall     = 1'b0;

    logic                     pix_stall;
    logic                     res_valid;
    logic                     kind;
    logic signed [1:0]        next_up_sign;
    logic signed [1:0]        start_up_sign;
    logic [CLASS_W-1:0]       class_index;
    logic signed [SUM_W-1:0]  class_sum;
    logic [CNT_W-1:0]         class_count;
    logic                     last;

    int   fail_count;
    int   pending;

    // Windows in which one side never idles, so back-to-back traffic is seen too.
    logic quiet_tx = 1'b0;
    logic quiet_rx = 1'b0;

    always #5 clk = ~clk;

    sao_edge_diag135_stats_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .cur_pixel     (cur_pixel),
        .diag_pixel    (diag_pixel),
        .up_sign       (up_sign),
        .diff          (diff),
        .row_start     (row_start),
        .left_pixel    (left_pixel),
        .below_pixel   (below_pixel),
        .end_of_block  (end_of_block),
        .clear_before  (clear_before),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .kind          (kind),
        .next_up_sign  (next_up_sign),
        .start_up_sign (start_up_sign),
        .class_index   (class_index),
        .class_sum     (class_sum),
        .class_count   (class_count),
        .last          (last)
    );

    sao_diag135_stats_checker stats_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .cur_pixel     (cur_pixel),
        .diag_pixel    (diag_pixel),
        .up_sign       (up_sign),
        .diff          (diff),
        .row_start     (row_start),
        .left_pixel    (left_pixel),
        .below_pixel   (below_pixel),
        .end_of_block  (end_of_block),
        .clear_before  (clear_before),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .kind          (kind),
        .next_up_sign  (next_up_sign),
        .start_up_sign (start_up_sign),
        .class_index   (class_index),
        .class_sum     (class_sum),
        .class_count   (class_count),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Receiver: stall at random about 12 percent of the time, except in the quiet window.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (quiet_rx)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99) < 12);
    end

    // Bias toward the extremes so the edge bits are hit often.
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIFF_W-1:0] rand_diff();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return DIFF_W'($urandom);
        endcase
    endfunction

    // Mostly legal stored signs, with the unused -2 code now and then.
    function automatic logic [1:0] rand_up();
        if ($urandom_range(15) == 0)
            return SIGN_CODE_BAD;
        case ($urandom_range(2))
            0:       return SIGN_CODE_NEG;
            1:       return SIGN_CODE_ZERO;
            default: return SIGN_CODE_POS;
        endcase
    endfunction

    // Drop valid for a random number of cycles before the next transaction.
    task automatic idle_gap();
        if (!quiet_tx)
        begin
            while ($urandom_range(99) < 12)
            begin
                pix_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Present one pixel transaction and hold it until the block takes it.
    task automatic send_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] dg,
                              input logic [1:0] up, input logic [DIFF_W-1:0] d,
                              input logic rs, input logic [PIX_W-1:0] lf,
                              input logic [PIX_W-1:0] bl, input logic eob, input logic clr);
        idle_gap();
        pix_valid    <= 1'b1;
        cur_pixel    <= cur;
        diag_pixel   <= dg;
        up_sign      <= up;
        diff         <= d;
        row_start    <= rs;
        left_pixel   <= lf;
        below_pixel  <= bl;
        end_of_block <= eob;
        clear_before <= clr;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
    endtask

    // Random content for one pixel; equal pairs are forced often to hit sign zero.
    task automatic send_random_pixel(input logic rs, input logic eob, input logic clr);
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] dg;
        logic [PIX_W-1:0] lf;
        logic [PIX_W-1:0] bl;
        cur = rand_pixel();
        dg  = ($urandom_range(3) == 0) ? cur : rand_pixel();
        lf  = rand_pixel();
        bl  = ($urandom_range(3) == 0) ? lf : rand_pixel();
        send_pixel(cur, dg, rand_up(), rand_diff(), rs, lf, bl, eob, clr);
    endtask

    initial
    begin
        int rand_items;
        int width;
        int rows;
        logic wipe;

        rand_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: every edge class, both sign extremes, row starts,
        // the saturated -2 up sign, clears with a pixel and end-of-block totals.
        send_pixel(8'd0,   8'd0,   SIGN_CODE_ZERO, 16'h0000, 1'b1, 8'd0,   8'd0,   1'b0, 1'b1);
        send_pixel(8'd255, 8'd0,   SIGN_CODE_POS,  16'h7FFF, 1'b0, 8'd255, 8'd0,   1'b0, 1'b0);
        send_pixel(8'd0,   8'd255, SIGN_CODE_NEG,  16'h8000, 1'b1, 8'd255, 8'd0,   1'b0, 1'b0);
        send_pixel(8'd128, 8'd128, SIGN_CODE_BAD,  16'hFFFF, 1'b1, 8'd0,   8'd255, 1'b0, 1'b0);
        send_pixel(8'd10,  8'd200, SIGN_CODE_POS,  16'h0001, 1'b0, 8'h55,  8'hAA,  1'b0, 1'b0);
        send_pixel(8'd200, 8'd10,  SIGN_CODE_ZERO, 16'h5555, 1'b0, 8'hAA,  8'h55,  1'b0, 1'b0);
        send_pixel(8'd200, 8'd10,  SIGN_CODE_NEG,  16'hAAAA, 1'b1, 8'hAA,  8'h55,  1'b0, 1'b0);
        send_pixel(8'd77,  8'd77,  SIGN_CODE_POS,  16'h1234, 1'b0, 8'd0,   8'd0,   1'b1, 1'b0);
        send_pixel(8'd1,   8'd0,   SIGN_CODE_BAD,  16'h8001, 1'b1, 8'd7,   8'd7,   1'b1, 1'b1);
        send_pixel(8'd0,   8'd1,   SIGN_CODE_ZERO, 16'h7FFE, 1'b1, 8'h55,  8'h55,  1'b1, 1'b0);
        send_pixel(8'hAA,  8'h55,  SIGN_CODE_POS,  16'h8000, 1'b0, 8'd0,   8'd0,   1'b0, 1'b1);
        send_pixel(8'h55,  8'hAA,  SIGN_CODE_NEG,  16'h7FFF, 1'b1, 8'd255, 8'd255, 1'b1, 1'b0);
        send_pixel(8'd255, 8'd255, SIGN_CODE_NEG,  16'hFFFF, 1'b0, 8'd0,   8'd0,   1'b1, 1'b0);
        send_pixel(8'd255, 8'd254, SIGN_CODE_BAD,  16'h0000, 1'b0, 8'd0,   8'd0,   1'b1, 1'b1);
        send_pixel(8'd3,   8'd4,   SIGN_CODE_POS,  16'hC000, 1'b1, 8'd254, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd9,   8'd9,   SIGN_CODE_ZERO, 16'h3FFF, 1'b0, 8'd0,   8'd0,   1'b1, 1'b0);

        // Random part: mostly well-formed blocks (rows of pixels closed by an
        // end-of-block pixel, often cleared first), with one in ten as noise.
        while (rand_items < RAND_ITEMS)
        begin
            quiet_rx <= (rand_items >= 60 && rand_items < 140);
            quiet_tx <= (rand_items >= 150 && rand_items < 230);
            if ($urandom_range(9) == 0)
            begin
                send_random_pixel(1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                rand_items++;
            end
            else
            begin
                width = $urandom_range(1, 6);
                rows  = $urandom_range(1, 4);
                wipe  = 1'($urandom_range(1));
                for (int r = 0; r < rows; r++)
                begin
                    for (int c = 0; c < width; c++)
                    begin
                        send_random_pixel(c == 0, r == rows - 1 && c == width - 1,
                                          wipe && r == 0 && c == 0);
                        rand_items++;
                    end
                end
            end
        end

        // Hold valid low, then drain every queued result before the verdict.
        pix_valid <= 1'b0;
        quiet_tx  <= 1'b0;
        quiet_rx  <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
